FILE: sv/fla_pkg.sv
// ----------------------------------------------------------------------------
// fla_pkg
// Shared types and constants of the free-list allocator.
// ----------------------------------------------------------------------------
package fla_pkg;

    localparam int ARENA_UNITS  = 4096;
    localparam int HEADER_BYTES = 16;
    localparam int UNIT_W       = $clog2(ARENA_UNITS);
    localparam int HB_SHIFT     = $clog2(HEADER_BYTES);
    localparam int BYTES_W      = 16;
    localparam int UNITS_W      = UNIT_W + 1;
    localparam int ASTEP_W      = UNIT_W + 2;
    localparam int RSTEP_W      = UNIT_W + 1;
    localparam int ALLOC_LIMIT  = 2 * ARENA_UNITS + 4;
    localparam int WALK_LIMIT   = ARENA_UNITS + 1;
    localparam logic [11:0] DEFAULT_MIN_GROW = 12'd1024;

    localparam logic       CMD_ALLOC = 1'b0;
    localparam logic       CMD_FREE  = 1'b1;
    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_BADSIZE = 2'd1;
    localparam logic [1:0] STAT_NOSPACE = 2'd2;

    typedef struct packed {
        logic [UNIT_W-1:0] next;
        logic [UNIT_W-1:0] size;
    } hdr_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_DISPATCH, ST_A_INIT, ST_A_RDPREV, ST_A_CAPPREV, ST_A_CHK,
        ST_A_SPLIT, ST_R_START, ST_R_WALK, ST_R_MERGE, ST_R_LINK, ST_F_RD,
        ST_F_CHK, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE, OP_LOAD, OP_INIT, OP_RDPREV, OP_CAPPREV, OP_FAIL, OP_EXACT,
        OP_SPLIT, OP_SPLIT2, OP_GROW, OP_ADVANCE, OP_RSTART, OP_RFOUND,
        OP_RNEXT, OP_RM1, OP_RM2, OP_FRD, OP_FSET, OP_PUSH
    } op_t;

    typedef struct packed {
        logic is_free;
        logic zero_bytes;
        logic started;
        logic addr_nz;
        logic alloc_lim;
        logic fit;
        logic exact;
        logic at_rover;
        logic grow_ok;
        logic found;
        logic walk_lim;
        logic ret_alloc;
        logic hdr_nz;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: sv/fla_ctrl.sv
// ----------------------------------------------------------------------------
// fla_ctrl
// Sequencer of the allocator: steps allocate, free and list insertion.
// ----------------------------------------------------------------------------
module fla_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    output logic                in_ready,
    input  fla_pkg::dp_status_t st,
    output fla_pkg::op_t        op
);
    import fla_pkg::*;

    state_t state_reg, state_next;
    state_t ret_state;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign ret_state = st.ret_alloc ? ST_A_RDPREV : ST_DONE;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                if (st.is_free) begin
                    state_next = (st.started && st.addr_nz) ? ST_F_RD : ST_DONE;
                end else if (st.zero_bytes) begin
                    state_next = ST_DONE;
                end else begin
                    state_next = st.started ? ST_A_RDPREV : ST_A_INIT;
                end
            end
            ST_A_INIT:    state_next = ST_A_RDPREV;
            ST_A_RDPREV:  state_next = ST_A_CAPPREV;
            ST_A_CAPPREV: state_next = ST_A_CHK;
            ST_A_CHK: begin
                priority if (st.alloc_lim) state_next = ST_DONE;
                else if (st.fit && st.exact) state_next = ST_DONE;
                else if (st.fit) state_next = ST_A_SPLIT;
                else if (st.at_rover) state_next = st.grow_ok ? ST_R_START : ST_DONE;
                else state_next = ST_A_CHK;
            end
            ST_A_SPLIT:   state_next = ST_DONE;
            ST_R_START:   state_next = ST_R_WALK;
            ST_R_WALK: begin
                priority if (st.found) state_next = ST_R_MERGE;
                else if (st.walk_lim) state_next = ret_state;
                else state_next = ST_R_WALK;
            end
            ST_R_MERGE:   state_next = ST_R_LINK;
            ST_R_LINK:    state_next = ret_state;
            ST_F_RD:      state_next = ST_F_CHK;
            ST_F_CHK:     state_next = st.hdr_nz ? ST_R_START : ST_DONE;
            ST_DONE:      if (!st.out_busy) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        op       = OP_NONE;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) op = OP_LOAD;
            end
            ST_DISPATCH:  op = OP_NONE;
            ST_A_INIT:    op = OP_INIT;
            ST_A_RDPREV:  op = OP_RDPREV;
            ST_A_CAPPREV: op = OP_CAPPREV;
            ST_A_CHK: begin
                priority if (st.alloc_lim) op = OP_FAIL;
                else if (st.fit && st.exact) op = OP_EXACT;
                else if (st.fit) op = OP_SPLIT;
                else if (st.at_rover) op = st.grow_ok ? OP_GROW : OP_FAIL;
                else op = OP_ADVANCE;
            end
            ST_A_SPLIT:   op = OP_SPLIT2;
            ST_R_START:   op = OP_RSTART;
            ST_R_WALK: begin
                priority if (st.found) op = OP_RFOUND;
                else if (st.walk_lim) op = OP_NONE;
                else op = OP_RNEXT;
            end
            ST_R_MERGE:   op = OP_RM1;
            ST_R_LINK:    op = OP_RM2;
            ST_F_RD:      op = OP_FRD;
            ST_F_CHK:     op = st.hdr_nz ? OP_FSET : OP_NONE;
            ST_DONE:      op = st.out_busy ? OP_NONE : OP_PUSH;
            default:      op = OP_NONE;
        endcase
    end

endmodule

FILE: sv/fla_datapath.sv
// ----------------------------------------------------------------------------
// fla_datapath
// Header memory, list pointers, arena break and the result register.
// ----------------------------------------------------------------------------
module fla_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  fla_pkg::op_t        op,
    output fla_pkg::dp_status_t st,
    input  logic                cfg_wr_en,
    input  logic [11:0]         cfg_wr_data,
    input  logic                in_cmd,
    input  logic [15:0]         in_bytes,
    input  logic [11:0]         in_addr,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [11:0]         out_addr,
    output logic [1:0]          out_status
);
    import fla_pkg::*;

    hdr_t mem [ARENA_UNITS];
    hdr_t rda, rdb, wr_data;
    logic [UNIT_W-1:0] rd_addr_a, rd_addr_b, wr_addr;
    logic wr_en;

    logic [11:0]        min_grow_reg;
    logic               cmd_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [UNIT_W-1:0]  addr_reg;
    logic [UNITS_W-1:0] units_reg;
    logic               started_reg, ret_alloc_reg;
    logic [UNIT_W-1:0]  rover_reg, prev_reg, p_reg, n_reg, bp_reg, q_reg;
    logic [UNIT_W:0]    brk_reg;
    hdr_t               hprev_reg, hp_reg, newb_reg;
    logic [ASTEP_W-1:0] asteps_reg;
    logic [RSTEP_W-1:0] rsteps_reg;
    logic [UNIT_W-1:0]  res_addr_reg;
    logic [1:0]         res_status_reg;
    logic               out_valid_reg;
    logic [11:0]        out_addr_reg;
    logic [1:0]         out_status_reg;

    logic [UNITS_W-1:0] in_units, nu;
    logic [UNIT_W+1:0]  grow_end;
    logic [UNIT_W-1:0]  split_size, split_q;
    logic               merge_hi, merge_lo;
    hdr_t               newb;

    always_ff @(posedge aclk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        rda <= mem[rd_addr_a];
        rdb <= mem[rd_addr_b];
    end

    assign in_units   = UNITS_W'((({1'b0, in_bytes} + 17'(HEADER_BYTES - 1)) >> HB_SHIFT)
                                 + 17'd1);
    assign nu         = (units_reg < {1'b0, min_grow_reg}) ? {1'b0, min_grow_reg} : units_reg;
    assign grow_end   = {1'b0, brk_reg} + {1'b0, nu};
    assign split_size = UNIT_W'({1'b0, rda.size} - units_reg);
    assign split_q    = p_reg + split_size;
    assign merge_hi   = ({1'b0, bp_reg} + {1'b0, rda.size}) == {1'b0, n_reg};
    assign newb       = merge_hi ? '{next: rdb.next, size: rda.size + rdb.size}
                                 : '{next: n_reg, size: rda.size};
    assign merge_lo   = ({1'b0, p_reg} + {1'b0, hp_reg.size}) == {1'b0, bp_reg};

    always_comb begin
        rd_addr_a = p_reg;
        rd_addr_b = n_reg;
        wr_en     = 1'b0;
        wr_addr   = p_reg;
        wr_data   = rda;
        unique case (op)
            OP_INIT: begin
                wr_en   = 1'b1;
                wr_addr = '0;
                wr_data = '0;
            end
            OP_RDPREV, OP_RSTART: rd_addr_a = rover_reg;
            OP_CAPPREV, OP_ADVANCE, OP_RNEXT: rd_addr_a = rda.next;
            OP_EXACT: begin
                wr_en   = 1'b1;
                wr_addr = prev_reg;
                wr_data = '{next: rda.next, size: hprev_reg.size};
            end
            OP_SPLIT: begin
                wr_en     = 1'b1;
                wr_addr   = p_reg;
                wr_data   = '{next: rda.next, size: split_size};
                rd_addr_a = split_q;
            end
            OP_SPLIT2: begin
                wr_en   = 1'b1;
                wr_addr = q_reg;
                wr_data = '{next: rda.next, size: units_reg[UNIT_W-1:0]};
            end
            OP_GROW: begin
                wr_en   = 1'b1;
                wr_addr = brk_reg[UNIT_W-1:0];
                wr_data = '{next: '0, size: nu[UNIT_W-1:0]};
            end
            OP_RFOUND: begin
                rd_addr_a = bp_reg;
                rd_addr_b = rda.next;
            end
            OP_RM1: begin
                wr_en   = 1'b1;
                wr_addr = bp_reg;
                wr_data = newb;
            end
            OP_RM2: begin
                wr_en   = 1'b1;
                wr_addr = p_reg;
                wr_data = merge_lo ? '{next: newb_reg.next, size: hp_reg.size + newb_reg.size}
                                   : '{next: bp_reg, size: hp_reg.size};
            end
            OP_FRD: rd_addr_a = addr_reg - 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            min_grow_reg  <= DEFAULT_MIN_GROW;
            started_reg   <= 1'b0;
            rover_reg     <= '0;
            brk_reg       <= (UNIT_W+1)'(1);
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) min_grow_reg <= cfg_wr_data;
            if (out_valid_reg && out_ready) out_valid_reg <= 1'b0;
            unique case (op)
                OP_LOAD: begin
                    cmd_reg        <= in_cmd;
                    bytes_reg      <= in_bytes;
                    addr_reg       <= in_addr;
                    units_reg      <= in_units;
                    asteps_reg     <= '0;
                    res_addr_reg   <= '0;
                    res_status_reg <= (in_cmd == CMD_ALLOC && in_bytes == '0)
                                      ? STAT_BADSIZE : STAT_OK;
                end
                OP_INIT: begin
                    started_reg <= 1'b1;
                    rover_reg   <= '0;
                end
                OP_CAPPREV: begin
                    prev_reg  <= rover_reg;
                    hprev_reg <= rda;
                    p_reg     <= rda.next;
                end
                OP_FAIL: res_status_reg <= STAT_NOSPACE;
                OP_EXACT: begin
                    rover_reg    <= prev_reg;
                    res_addr_reg <= p_reg + 1'b1;
                end
                OP_SPLIT: q_reg <= split_q;
                OP_SPLIT2: begin
                    rover_reg    <= prev_reg;
                    res_addr_reg <= q_reg + 1'b1;
                end
                OP_GROW: begin
                    bp_reg        <= brk_reg[UNIT_W-1:0];
                    brk_reg       <= grow_end[UNIT_W:0];
                    ret_alloc_reg <= 1'b1;
                    asteps_reg    <= asteps_reg + 1'b1;
                end
                OP_ADVANCE: begin
                    prev_reg   <= p_reg;
                    hprev_reg  <= rda;
                    p_reg      <= rda.next;
                    asteps_reg <= asteps_reg + 1'b1;
                end
                OP_RSTART: begin
                    p_reg      <= rover_reg;
                    rsteps_reg <= '0;
                end
                OP_RFOUND: begin
                    n_reg  <= rda.next;
                    hp_reg <= rda;
                end
                OP_RNEXT: begin
                    p_reg      <= rda.next;
                    rsteps_reg <= rsteps_reg + 1'b1;
                end
                OP_RM1: newb_reg <= newb;
                OP_RM2: rover_reg <= p_reg;
                OP_FSET: begin
                    bp_reg        <= addr_reg - 1'b1;
                    ret_alloc_reg <= 1'b0;
                end
                OP_PUSH: begin
                    out_valid_reg  <= 1'b1;
                    out_addr_reg   <= res_addr_reg;
                    out_status_reg <= res_status_reg;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        st.is_free    = (cmd_reg == CMD_FREE);
        st.zero_bytes = (bytes_reg == '0);
        st.started    = started_reg;
        st.addr_nz    = (addr_reg != '0);
        st.alloc_lim  = (asteps_reg == ASTEP_W'(ALLOC_LIMIT));
        st.fit        = ({1'b0, rda.size} >= units_reg);
        st.exact      = ({1'b0, rda.size} == units_reg);
        st.at_rover   = (p_reg == rover_reg);
        st.grow_ok    = (grow_end <= (UNIT_W+2)'(ARENA_UNITS));
        st.found      = (bp_reg > p_reg && bp_reg < rda.next)
                        || (p_reg >= rda.next && (bp_reg > p_reg || bp_reg < rda.next));
        st.walk_lim   = (rsteps_reg == RSTEP_W'(WALK_LIMIT));
        st.ret_alloc  = ret_alloc_reg;
        st.hdr_nz     = (rda.size != '0);
        st.out_busy   = out_valid_reg && !out_ready;
    end

    assign out_valid  = out_valid_reg;
    assign out_addr   = out_addr_reg;
    assign out_status = out_status_reg;

endmodule

FILE: sv/free_list_allocator.sv
// ----------------------------------------------------------------------------
// free_list_allocator
// Next-fit free-list allocator with coalescing over a header-unit arena.
// ----------------------------------------------------------------------------
//  Channel  Direction  Payload
//  s_       in         tuser: command; tdata: request_bytes, block_address
//  m_       out        tuser: status; tdata: granted_address
//  cfg_     in         min_grow_units
//
//  An allocate checks free-list nodes from the rover, splits a larger block
//  and sets up the list on the first allocate; a growth adds the new block
//  to the list by an insertion walk. A free also walks to its insertion
//  point, unless it is ignored; a zero-byte allocate does no walk.
//  Reset is synchronous; the header memory is not cleared.
//  A result waiting on m_tready does not stop the next beat being taken.
// ----------------------------------------------------------------------------
module free_list_allocator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // request_bytes [15:0], block_address [27:16]
    input  logic [0:0]  s_tuser,   // command [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // granted_address [11:0]
    output logic [1:0]  m_tuser,   // status [1:0]
    input  logic        cfg_wr_en,
    input  logic [11:0] cfg_wr_data
);
    import fla_pkg::*;

    op_t        op;
    dp_status_t st;
    logic [11:0] granted;

    fla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .st       (st),
        .op       (op)
    );

    fla_datapath u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .op          (op),
        .st          (st),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_cmd      (s_tuser[0]),
        .in_bytes    (s_tdata[15:0]),
        .in_addr     (s_tdata[27:16]),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_addr    (granted),
        .out_status  (m_tuser)
    );

    assign m_tdata = {4'b0, granted};

endmodule

FILE: sv/fla_checker.sv
// ----------------------------------------------------------------------------
// fla_checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
module fla_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser
);
    import fla_pkg::*;

    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("Result valid after reset.");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tuser == STAT_OK || m_tuser == STAT_BADSIZE
                      || m_tuser == STAT_NOSPACE))
        else $error("Unknown status code.");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser != STAT_OK) |-> (m_tdata == 16'd0))
        else $error("Failed beat carries an address.");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("Beat taken while busy.");

endmodule

bind free_list_allocator fla_checker u_fla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

FILE: verif/free_list_allocator_tb.sv
// ----------------------------------------------------------------------------
// free_list_allocator_tb
// Self-checking bench for the next-fit free-list allocator. A queue of
// allocate and free beats feeds a bursty driver, while a stalling monitor
// compares every result beat with a software copy of the arena.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module free_list_allocator_tb;
    import fla_pkg::*;

    typedef struct {
        logic        cmd;
        logic [15:0] nbytes;
        logic [11:0] addr;
    } req_t;

    typedef struct {
        logic [11:0] grant;
        logic [1:0]  status;
    } resp_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        cfg_wr_en = 1'b0;
    logic [11:0] cfg_wr_data = '0;

    req_t  req_q[$];
    resp_t resp_pending_q[$];
    resp_t resp_expected_q[$];

    int hdr_next[ARENA_UNITS];
    int hdr_size[ARENA_UNITS];
    int rover_unit;
    bit list_live;
    int brk_unit;
    int grow_min;
    int owned_q[$];
    int released_q[$];

    int errors = 0;
    int burst_left = 0;
    int gap_left = 0;
    int stall_mode = 0;
    int cycle_count = 0;

    free_list_allocator uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic void link_free_block(int bp);
        int p;
        int n;
        int steps;
        p = rover_unit;
        steps = 0;
        forever begin
            n = hdr_next[p];
            if (bp > p && bp < n) break;
            if (p >= n && (bp > p || bp < n)) break;
            steps++;
            if (steps > WALK_LIMIT) return;
            p = n;
        end
        if (bp + hdr_size[bp] == n) begin
            hdr_size[bp] = (hdr_size[bp] + hdr_size[n]) & 12'hFFF;
            hdr_next[bp] = hdr_next[n];
        end else begin
            hdr_next[bp] = n;
        end
        if (p + hdr_size[p] == bp) begin
            hdr_size[p] = (hdr_size[p] + hdr_size[bp]) & 12'hFFF;
            hdr_next[p] = hdr_next[bp];
        end else begin
            hdr_next[p] = bp;
        end
        rover_unit = p;
    endfunction

    function automatic bit grow_arena(int units);
        int nu;
        nu = (units < grow_min) ? grow_min : units;
        if (brk_unit + nu > ARENA_UNITS) return 1'b0;
        hdr_size[brk_unit] = nu & 12'hFFF;
        link_free_block(brk_unit);
        brk_unit = brk_unit + nu;
        return 1'b1;
    endfunction

    function automatic resp_t allocator_response(req_t r);
        resp_t res;
        int units;
        int prev;
        int p;
        res.grant = '0;
        res.status = STAT_OK;
        if (r.cmd == CMD_FREE) begin
            if (list_live && r.addr != 0 && hdr_size[r.addr - 1] != 0)
                link_free_block(r.addr - 1);
            return res;
        end
        if (r.nbytes == 0) begin
            res.status = STAT_BADSIZE;
            return res;
        end
        units = (r.nbytes + HEADER_BYTES - 1) / HEADER_BYTES + 1;
        if (!list_live) begin
            list_live = 1'b1;
            hdr_next[0] = 0;
            hdr_size[0] = 0;
            rover_unit = 0;
        end
        prev = rover_unit;
        p = hdr_next[prev];
        for (int steps = 0; steps < ALLOC_LIMIT; steps++) begin
            if (hdr_size[p] >= units) begin
                if (hdr_size[p] == units) begin
                    hdr_next[prev] = hdr_next[p];
                end else begin
                    hdr_size[p] = hdr_size[p] - units;
                    p = (p + hdr_size[p]) % ARENA_UNITS;
                    hdr_size[p] = units & 12'hFFF;
                end
                rover_unit = prev;
                res.grant = 12'(p + 1);
                return res;
            end
            if (p == rover_unit) begin
                if (!grow_arena(units)) begin
                    res.status = STAT_NOSPACE;
                    return res;
                end
                p = rover_unit;
            end
            prev = p;
            p = hdr_next[p];
        end
        res.status = STAT_NOSPACE;
        return res;
    endfunction

    task automatic queue_request(logic cmd, logic [15:0] nbytes, logic [11:0] addr);
        req_t r;
        resp_t res;
        r.cmd = cmd;
        r.nbytes = nbytes;
        r.addr = addr;
        res = allocator_response(r);
        if (cmd == CMD_ALLOC && res.status == STAT_OK) owned_q.push_back(int'(res.grant));
        req_q.push_back(r);
        resp_pending_q.push_back(res);
    endtask

    task automatic free_owned();
        int k;
        k = $urandom_range(0, owned_q.size() - 1);
        queue_request(CMD_FREE, 16'($urandom), 12'(owned_q[k]));
        released_q.push_back(owned_q[k]);
        owned_q.delete(k);
    endtask

    task automatic random_request();
        int pick;
        logic [15:0] nb;
        pick = $urandom_range(0, 99);
        if (pick < 1 && released_q.size() > 0) begin
            queue_request(CMD_FREE, 16'($urandom),
                          12'(released_q[$urandom_range(0, released_q.size() - 1)]));
        end else if (pick < 3) begin
            queue_request(CMD_FREE, 16'($urandom), 12'd0);
        end else if (owned_q.size() > 0 && pick < ((owned_q.size() > 40) ? 65 : 40)) begin
            free_owned();
        end else begin
            pick = $urandom_range(0, 99);
            if (pick < 70) nb = 16'($urandom_range(1, 64));
            else if (pick < 90) nb = 16'($urandom_range(65, 1024));
            else if (pick < 95) nb = 16'($urandom);
            else nb = 16'd0;
            queue_request(CMD_ALLOC, nb, 12'($urandom));
        end
    endtask

    task automatic wait_idle_and_config(logic [11:0] value);
        while (req_q.size() != 0 || resp_expected_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        grow_min = int'(value);
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                resp_expected_q.push_back(resp_pending_q.pop_front());
                void'(req_q.pop_front());
                if (burst_left > 0) burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (req_q.size() > 0) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {4'b0, req_q[0].addr, req_q[0].nbytes};
                    s_tuser <= req_q[0].cmd;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge aclk) begin
        resp_t e;
        cycle_count++;
        if (cycle_count % 300 == 0) stall_mode = $urandom_range(0, 2);
        if (aresetn && m_tvalid && m_tready) begin
            if (resp_expected_q.size() == 0) begin
                errors++;
                if (errors <= 10) $display("Unexpected result beat: grant %0d status %0d",
                                           m_tdata[11:0], m_tuser);
            end else begin
                e = resp_expected_q.pop_front();
                if (m_tdata[11:0] !== e.grant || m_tuser !== e.status) begin
                    errors++;
                    if (errors <= 10)
                        $display("Mismatch: expected grant %0d status %0d, got %0d status %0d",
                                 e.grant, e.status, m_tdata[11:0], m_tuser);
                end
            end
        end
        case (stall_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 3) != 0);
            default: m_tready <= ($urandom_range(0, 2) == 0);
        endcase
    end

    initial begin
        for (int i = 0; i < ARENA_UNITS; i++) begin
            hdr_next[i] = 0;
            hdr_size[i] = 0;
        end
        rover_unit = 0;
        list_live = 1'b0;
        brk_unit = 1;
        grow_min = DEFAULT_MIN_GROW;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Frees before the list exists are ignored.
        queue_request(CMD_FREE, 16'hFFFF, 12'd4095);
        queue_request(CMD_FREE, 16'd0, 12'd0);
        queue_request(CMD_FREE, 16'h5A5A, 12'd1234);
        queue_request(CMD_ALLOC, 16'd0, 12'd0);
        queue_request(CMD_ALLOC, 16'd1, 12'hFFF);
        queue_request(CMD_ALLOC, 16'd16, 12'd0);
        queue_request(CMD_ALLOC, 16'd17, 12'd0);
        queue_request(CMD_ALLOC, 16'hFFFF, 12'd0);
        queue_request(CMD_ALLOC, 16'd65519, 12'd0);
        queue_request(CMD_FREE, 16'd0, 12'd0);
        free_owned();
        queue_request(CMD_ALLOC, 16'd1, 12'd0);
        queue_request(CMD_ALLOC, 16'd32, 12'd0);
        free_owned();
        free_owned();
        queue_request(CMD_ALLOC, 16'd20000, 12'd0);
        queue_request(CMD_ALLOC, 16'd48, 12'd0);
        free_owned();

        wait_idle_and_config(12'd1);
        repeat (400) random_request();
        wait_idle_and_config(12'd4095);
        repeat (400) random_request();
        wait_idle_and_config(12'($urandom_range(1, 4095)));
        repeat (400) random_request();
        wait_idle_and_config(DEFAULT_MIN_GROW);
        while (owned_q.size() > 0) free_owned();
        repeat (400) random_request();

        while (req_q.size() != 0 || resp_expected_q.size() != 0 || s_tvalid)
            @(posedge aclk);
        repeat (50) @(posedge aclk);
        if (resp_expected_q.size() != 0) errors++;
        if (errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5s;
        $display("DONE: errors detected");
        $finish;
    end

endmodule
